@@ rtl/stbs_pkg.sv @@
// shared types and constants for the sorted table search block
package stbs_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;
    localparam int POS_W   = 5;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic write_entry;
        logic start;
        logic step;
        logic take_result;
    } stbs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic hit;
        logic more;
    } stbs_status_t;

endpackage

@@ rtl/stbs_ram.sv @@
// generic simple dual port ram with registered read
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/stbs_datapath.sv @@
// search datapath: bounds, table ram, key compare and result registers
module stbs_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stbs_pkg::stbs_cmd_t              cmd,
    output stbs_pkg::stbs_status_t           status,
    input  logic [stbs_pkg::INDEX_W-1:0]     entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0] data_value,
    input  logic                             cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]     cfg_wr_data,
    output logic                             found,
    output logic [stbs_pkg::POS_W-1:0]       position
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [stbs_pkg::COUNT_W-1:0]       entries_in_use_reg, entries_in_use_next;
    logic signed [stbs_pkg::DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]                   lo_reg, lo_next;
    logic [CNT_W-1:0]                   hi_reg, hi_next;
    logic [IDX_W-1:0]                   mid_reg, mid_next;
    logic                               srch_found_reg, srch_found_next;
    logic [stbs_pkg::POS_W-1:0]         srch_pos_reg, srch_pos_next;
    logic                               found_reg, found_next;
    logic [stbs_pkg::POS_W-1:0]         position_reg, position_next;

    logic [CNT_W-1:0]                   count;
    logic [CNT_W:0]                     sum;
    logic [CNT_W-1:0]                   mid_wide;
    logic [IDX_W-1:0]                   rd_addr;
    logic [IDX_W-1:0]                   wr_addr;
    logic                               wr_en;
    logic [stbs_pkg::DATA_W-1:0]        rd_data;
    logic                               probe_eq;
    logic                               probe_gt;

    // entry count saturates at the table depth
    assign count = (32'(entries_in_use_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entries_in_use_reg);

    assign wr_en   = cmd.write_entry && (32'(entry_index) < TABLE_DEPTH);
    assign wr_addr = IDX_W'(32'(entry_index));

    assign probe_eq = (rd_data == key_reg);
    assign probe_gt = ($signed(rd_data) > key_reg);

    always_comb
    begin
        entries_in_use_next = cfg_wr_en ? cfg_wr_data : entries_in_use_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        srch_found_next = srch_found_reg;
        srch_pos_next   = srch_pos_reg;
        found_next      = found_reg;
        position_next   = position_reg;

        if (cmd.start)
        begin
            key_next        = data_value;
            lo_next         = '0;
            hi_next         = count;
            srch_found_next = 1'b0;
            srch_pos_next   = '0;
        end
        else if (cmd.step)
        begin
            if (probe_gt)
            begin
                hi_next = CNT_W'(mid_reg);
            end
            else
            begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
            if (probe_eq)
            begin
                srch_found_next = 1'b1;
                srch_pos_next   = stbs_pkg::POS_W'(32'(mid_reg));
            end
        end

        if (cmd.take_result)
        begin
            found_next    = srch_found_reg;
            position_next = srch_pos_reg;
        end

        // next probe sits at floor((lo + hi_incl) / 2), hi kept exclusive
        sum      = {1'b0, lo_next} + {1'b0, hi_next} - (CNT_W + 1)'(1);
        mid_wide = sum[CNT_W:1];
        rd_addr  = mid_wide[IDX_W-1:0];
        mid_next = (cmd.start || cmd.step) ? rd_addr : mid_reg;
    end

    assign status.count_zero = (count == '0);
    assign status.hit        = probe_eq;
    assign status.more       = (lo_next < hi_next);

    stbs_ram #(
        .WIDTH (stbs_pkg::DATA_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_value),
        .rd_en   (cmd.start || cmd.step),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else
        begin
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        srch_found_reg <= srch_found_next;
        srch_pos_reg   <= srch_pos_next;
        found_reg      <= found_next;
        position_reg   <= position_next;
    end

    assign found    = found_reg;
    assign position = position_reg;

`ifndef SYNTHESIS
    a_bounds_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> lo_reg < hi_reg)
        else $error("probe issued with empty search range");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (CNT_W'(mid_reg) >= lo_reg) && (CNT_W'(mid_reg) < hi_reg))
        else $error("probe index outside search range");
`endif

endmodule

@@ rtl/stbs_ctrl.sv @@
// controller state machine: input transaction decode, probe loop, result handoff
module stbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    output logic                   out_valid,
    input  logic                   out_stall,
    output stbs_pkg::stbs_cmd_t    cmd,
    input  stbs_pkg::stbs_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == stbs_pkg::OP_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.count_zero ? ST_FINISH : ST_SEARCH;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.hit || !status.more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.take_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    a_empty_skips_probe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && status.count_zero |=> state_reg == ST_FINISH)
        else $error("empty table search entered probe loop");
`endif

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// top level of the sorted table binary search block
// a load keeps the controller idle; the next transaction is taken on the following cycle
// a search probes then finishes, probes = floor(log2(count)) + 1 at most, 6 for 32 entries
// one probe per cycle, set by the registered read port of the table ram
// an empty search skips the probe loop; the result register frees the input side once loaded
// reset clears entries_in_use and control state; table contents stay undefined until loaded
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [stbs_pkg::INDEX_W-1:0]       entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0] data_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [stbs_pkg::POS_W-1:0]         position,
    input  logic                               cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]       cfg_wr_data
);

    stbs_pkg::stbs_cmd_t    cmd;
    stbs_pkg::stbs_status_t status;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (entry_index),
        .data_value  (data_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .found       (found),
        .position    (position)
    );

endmodule

@@ tb/sv/tb_sorted_table_binary_search.sv @@
// testbench for the sorted table binary search block: loads, lookups and count settings
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;

    localparam int TABLE_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 14;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    localparam int STYLE_SPREAD   = 0;
    localparam int STYLE_DENSE    = 1;
    localparam int STYLE_EXTREMES = 2;
    localparam int STYLE_UNSORTED = 3;

    localparam logic signed [stbs_pkg::DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::POS_W-1:0] position;
    } lookup_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                op;
    logic [stbs_pkg::INDEX_W-1:0]        entry_index;
    logic signed [stbs_pkg::DATA_W-1:0]  data_value;
    logic                                out_valid;
    logic                                out_stall;
    logic                                found;
    logic [stbs_pkg::POS_W-1:0]          position;
    logic                                cfg_wr_en;
    logic [stbs_pkg::COUNT_W-1:0]        cfg_wr_data;

    // mirror of the block state
    logic signed [stbs_pkg::DATA_W-1:0]  table_mirror [TABLE_DEPTH];
    logic [stbs_pkg::COUNT_W-1:0]        count_mirror;

    lookup_result_t            expected_lookups [$];
    lookup_result_t            oldest_lookup;

    bit                        idle_on;
    int                        stall_left;
    int                        calm_left;
    int                        cycle_count;
    int                        mismatches;
    int                        loads_sent;
    int                        searches_sent;
    int                        hits_seen;
    int                        count_writes;

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_lookups.size());
            $display("** sorted_table_binary_search: FAILED **");
            $finish;
        end
    end

    // receiver stalls: random bursts separated by calm stretches
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_on)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (calm_left > 0)
            begin
                out_stall <= 1'b0;
                calm_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(1, 11);
                else
                    calm_left = $urandom_range(1, 40);
            end
        end
    end

    // binary search over the mirrored table, same probe order as the block
    function automatic lookup_result_t predict_lookup(
        logic signed [stbs_pkg::DATA_W-1:0] key);
        lookup_result_t r;
        int lo;
        int hi;
        int mid;
        r  = '0;
        lo = 0;
        hi = ((count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror)) - 1;
        while (!r.found && lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (table_mirror[mid] == key)
            begin
                r.found    = 1'b1;
                r.position = stbs_pkg::POS_W'(mid);
            end
            else if (table_mirror[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: found=%0b position=%0d", found, position);
            end
            else
            begin
                oldest_lookup = expected_lookups.pop_front();
                if (found !== oldest_lookup.found || position !== oldest_lookup.position)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected found=%0b position=%0d, ",
                                  "got found=%0b position=%0d"},
                                 oldest_lookup.found, oldest_lookup.position, found, position);
                end
                else if (found)
                    hits_seen++;
            end
        end
    end

    task automatic send_item(input logic item_op, input logic [stbs_pkg::INDEX_W-1:0] idx,
                             input logic signed [stbs_pkg::DATA_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= item_op;
        entry_index <= idx;
        data_value  <= value;
        do
            @(posedge clk);
        while (in_stall);
        if (item_op == stbs_pkg::OP_LOAD)
        begin
            table_mirror[idx] = value;
            loads_sent++;
        end
        else
        begin
            expected_lookups.push_back(predict_lookup(value));
            searches_sent++;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        // a trailing load may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries_in_use(input logic [stbs_pkg::COUNT_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        count_mirror  = value;
        count_writes++;
    endtask

    task automatic send_random_search();
        int eff;
        int pick;
        logic signed [stbs_pkg::DATA_W-1:0] key;
        eff  = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            key = table_mirror[(eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 31)];
        else if (pick < 7)
            key = table_mirror[$urandom_range(0, TABLE_DEPTH - 1)]
                  + (($urandom_range(0, 1) == 0) ? 1 : -1);
        else if (pick < 9)
            key = $urandom();
        else
            key = ($urandom_range(0, 1) == 0) ? MOST_NEGATIVE : MOST_POSITIVE;
        // entry not loaded yet during the first fill
        if ($isunknown(key))
            key = $urandom();
        send_item(stbs_pkg::OP_SEARCH, stbs_pkg::INDEX_W'($urandom()), key);
    endtask

    // fill the whole table with occasional lookups, then search under two count settings with occasional loads
    task automatic run_table_round(input int style,
                                   input logic [stbs_pkg::COUNT_W-1:0] count_a,
                                   input logic [stbs_pkg::COUNT_W-1:0] count_b);
        int vals [$];
        int order [$];
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            order.push_back(i);
            if (style == STYLE_DENSE)
                vals.push_back((i == 0) ? int'($urandom_range(0, 1000)) - 500
                                        : vals[i - 1] + int'($urandom_range(0, 3)));
            else
                vals.push_back(int'($urandom()));
        end
        if (style != STYLE_UNSORTED && style != STYLE_DENSE)
            vals.sort();
        if (style == STYLE_EXTREMES)
        begin
            vals[0]               = MOST_NEGATIVE;
            vals[TABLE_DEPTH - 1] = MOST_POSITIVE;
        end
        order.shuffle();
        foreach (order[k])
        begin
            send_item(stbs_pkg::OP_LOAD, stbs_pkg::INDEX_W'(order[k]), vals[order[k]]);
            // the prefix under the current count is always written, so a lookup is safe here
            if ($urandom_range(0, 7) == 0)
                send_random_search();
        end
        write_entries_in_use(count_a);
        repeat (15)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(stbs_pkg::OP_LOAD, stbs_pkg::INDEX_W'($urandom()), $urandom());
            send_random_search();
        end
        write_entries_in_use(count_b);
        repeat (15)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(stbs_pkg::OP_LOAD, stbs_pkg::INDEX_W'($urandom()), $urandom());
            send_random_search();
        end
    endtask

    // count still at its reset value of zero, nothing loaded
    task automatic test_empty_table();
        send_item(stbs_pkg::OP_SEARCH, '0, '0);
        send_item(stbs_pkg::OP_SEARCH, '1, MOST_NEGATIVE);
        send_item(stbs_pkg::OP_SEARCH, 5'd17, -1);
    endtask

    task automatic test_small_table_lookups();
        send_item(stbs_pkg::OP_LOAD, 5'd0, MOST_NEGATIVE);
        send_item(stbs_pkg::OP_LOAD, 5'd1, -5);
        send_item(stbs_pkg::OP_LOAD, 5'd2, 0);
        send_item(stbs_pkg::OP_LOAD, 5'd3, 7);
        send_item(stbs_pkg::OP_LOAD, 5'd4, MOST_POSITIVE);
        write_entries_in_use(6'd5);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, MOST_NEGATIVE);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, -5);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, 0);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, 7);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, MOST_POSITIVE);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, -6);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, 3);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, MOST_NEGATIVE + 1);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, MOST_POSITIVE - 1);
    endtask

    task automatic test_single_entry();
        write_entries_in_use(6'd1);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, MOST_NEGATIVE);
        send_item(stbs_pkg::OP_SEARCH, 5'd0, 0);
    endtask

    // includes counts above the table depth and an unsorted table
    task automatic test_random_tables();
        run_table_round(STYLE_SPREAD,   6'd32, 6'd63);
        run_table_round(STYLE_DENSE,    6'd17, 6'd1);
        run_table_round(STYLE_EXTREMES, 6'd32, 6'd0);
        run_table_round(STYLE_UNSORTED, 6'd31, 6'd33);
        run_table_round(STYLE_DENSE,    6'd32, stbs_pkg::COUNT_W'($urandom_range(0, 63)));
        run_table_round(STYLE_SPREAD,   6'd2,  6'd16);
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        run_table_round(STYLE_EXTREMES, 6'd32, stbs_pkg::COUNT_W'($urandom_range(0, 63)));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = stbs_pkg::OP_LOAD;
        entry_index = '0;
        data_value  = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        count_mirror = '0;
        idle_on     = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_small_table_lookups();
        test_single_entry();
        test_random_tables();
        test_full_rate();

        wait_for_results();
        repeat (20) @(posedge clk);

        $display("sent %0d loads and %0d lookups (%0d hits) across %0d count settings",
                 loads_sent, searches_sent, hits_seen, count_writes);
        $display("tables: sorted, dense with duplicates, full-range extremes, unsorted");
        if (mismatches == 0)
            $display("** sorted_table_binary_search: PASSED **");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** sorted_table_binary_search: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_datapath.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
tb/sv/tb_sorted_table_binary_search.sv
